// File: rtl/kre_pkg.sv
// Shared constants, types and keycode tables for the keyboard report event extractor.
package kre_pkg;

    localparam int REPORT_SLOTS = 6;
    localparam int INPUT_SLOTS  = 6;
    localparam int EVENT_SLOTS  = 2 * REPORT_SLOTS;
    localparam int EVT_W        = $clog2(EVENT_SLOTS);
    localparam int BUTTONS      = 16;

    localparam logic [7:0] MOD_CTRL     = 8'h11;
    localparam logic [7:0] MOD_SHIFT    = 8'h22;
    localparam logic [7:0] MOD_ALT      = 8'h44;
    localparam logic [7:0] KEY_DELETE   = 8'h4C;
    localparam logic [7:0] KEY_A        = 8'h04;
    localparam logic [7:0] KEY_Z        = 8'h1D;
    localparam logic [7:0] KEY_1        = 8'h1E;
    localparam logic [7:0] KEY_9        = 8'h26;
    localparam logic [7:0] KEY_0        = 8'h27;
    localparam logic [7:0] KEY_SPACE    = 8'h2C;
    localparam logic [7:0] KEY_BKSP     = 8'h2A;

    localparam logic [6:0] CHAR_UPPER_A = 7'h41;
    localparam logic [6:0] CHAR_LOWER_A = 7'h61;
    localparam logic [6:0] CHAR_ONE     = 7'h31;
    localparam logic [6:0] CHAR_ZERO    = 7'h30;
    localparam logic [6:0] CHAR_SPACE   = 7'h20;
    localparam logic [6:0] CHAR_BKSP    = 7'h08;

    typedef struct packed {
        logic       has;
        logic [3:0] idx;
    } kre_button_t;

    typedef struct packed {
        logic        press;
        logic        gone;
        logic [7:0]  cur_code;
        logic [7:0]  prev_code;
        kre_button_t cur_btn;
        kre_button_t prev_btn;
        logic [6:0]  text;
    } kre_lane_t;

    function automatic kre_button_t button_of(input logic [7:0] code);
        kre_button_t b;
        b.has = 1'b1;
        case (code)
            8'h52:   b.idx = 4'd0;
            8'h51:   b.idx = 4'd1;
            8'h50:   b.idx = 4'd2;
            8'h4F:   b.idx = 4'd3;
            8'h1B:   b.idx = 4'd4;
            8'h1D:   b.idx = 4'd5;
            8'h16:   b.idx = 4'd6;
            8'h04:   b.idx = 4'd7;
            8'h14:   b.idx = 4'd8;
            8'h1A:   b.idx = 4'd9;
            8'h28:   b.idx = 4'd10;
            8'h58:   b.idx = 4'd10;
            8'h2C:   b.idx = 4'd11;
            8'h29:   b.idx = 4'd12;
            8'h45:   b.idx = 4'd13;
            8'h44:   b.idx = 4'd14;
            8'h2B:   b.idx = 4'd15;
            default:
            begin
                b.has = 1'b0;
                b.idx = 4'd0;
            end
        endcase
        return b;
    endfunction

    function automatic logic [6:0] text_of(input logic [7:0] code, input logic shift);
        logic [6:0] ch;
        ch = 7'd0;
        if (code >= KEY_A && code <= KEY_Z)
        begin
            ch = (shift ? CHAR_UPPER_A : CHAR_LOWER_A) + 7'(code - KEY_A);
        end
        else if (code >= KEY_1 && code <= KEY_9)
        begin
            ch = CHAR_ONE + 7'(code - KEY_1);
        end
        else if (code == KEY_0)
        begin
            ch = CHAR_ZERO;
        end
        else if (code == KEY_SPACE)
        begin
            ch = CHAR_SPACE;
        end
        else if (code == KEY_BKSP)
        begin
            ch = CHAR_BKSP;
        end
        return ch;
    endfunction

endpackage

// File: rtl/kre_report_if.sv
// Handshake channel carrying one boot keyboard report.
interface kre_report_if;
    logic       valid;
    logic       ready;
    logic [7:0] modifier_bits;
    logic [7:0] slot0_code;
    logic [7:0] slot1_code;
    logic [7:0] slot2_code;
    logic [7:0] slot3_code;
    logic [7:0] slot4_code;
    logic [7:0] slot5_code;

    modport source (
        output valid, modifier_bits, slot0_code, slot1_code, slot2_code,
               slot3_code, slot4_code, slot5_code,
        input  ready
    );

    modport sink (
        input  valid, modifier_bits, slot0_code, slot1_code, slot2_code,
               slot3_code, slot4_code, slot5_code,
        output ready
    );
endinterface

// File: rtl/kre_result_if.sv
// Handshake channel carrying one key event or report status result.
interface kre_result_if;
    logic        valid;
    logic        ready;
    logic        is_event;
    logic        pressed;
    logic [7:0]  event_code;
    logic        has_button;
    logic [3:0]  button_index;
    logic [6:0]  text_char;
    logic [15:0] button_bits;
    logic        chord_reset;
    logic        last;

    modport source (
        output valid, is_event, pressed, event_code, has_button, button_index,
               text_char, button_bits, chord_reset, last,
        input  ready
    );

    modport sink (
        input  valid, is_event, pressed, event_code, has_button, button_index,
               text_char, button_bits, chord_reset, last,
        output ready
    );
endinterface

// File: rtl/keyboard_report_event_extractor_top.sv
// Top level of the keyboard report event extractor.
//
// Channels: report (sink) takes one boot keyboard report per transaction:
// modifier byte and six key slots. result (source) gives the key events of
// that report, presses in slot order then releases in slot order, each with
// keycode, game button, press text and held button mask, followed by one
// status result with last set that carries the mask and the Ctrl+Alt+Del
// chord flag.
// With the emitter idle, the first result of a report passes the lane buffer,
// then the emitter, then the output register. A report with n events gives
// n+1 results, so 1 to 13 per report, one at a time from the single emitter.
// Reports are diffed by six parallel lanes at acceptance, and one report may
// wait in the lane buffer while the previous one is still being emitted, so
// ready stays high while the lane buffer is empty or is passing into the emitter.
// Reset clears the stored previous report and the held button mask to zero.
// When the receiver holds ready low, the current result stays in the output
// register, the emitter holds, and report ready falls once the buffer fills.
module keyboard_report_event_extractor_top
    import kre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    kre_report_if.sink  report,
    kre_result_if.source result
);

    logic [7:0] in_codes [INPUT_SLOTS];
    logic [7:0] cur_codes [REPORT_SLOTS];
    logic [7:0] prev_reg [REPORT_SLOTS];
    kre_lane_t  lanes [REPORT_SLOTS];
    logic       in_fire;
    logic       in_ready;
    logic       del_seen;
    logic       chord;

    assign in_codes[0] = report.slot0_code;
    assign in_codes[1] = report.slot1_code;
    assign in_codes[2] = report.slot2_code;
    assign in_codes[3] = report.slot3_code;
    assign in_codes[4] = report.slot4_code;
    assign in_codes[5] = report.slot5_code;

    assign report.ready = in_ready;
    assign in_fire      = report.valid && in_ready;

    genvar gi;
    generate
        for (gi = 0; gi < REPORT_SLOTS; gi++)
        begin : g_lane
            if (gi < INPUT_SLOTS)
            begin : g_src
                assign cur_codes[gi] = in_codes[gi];
            end
            else
            begin : g_empty
                assign cur_codes[gi] = 8'd0;
            end

            kre_lane u_lane (
                .cur_code      (cur_codes[gi]),
                .prev_code     (prev_reg[gi]),
                .cur_all       (cur_codes),
                .prev_all      (prev_reg),
                .modifier_bits (report.modifier_bits),
                .lane          (lanes[gi])
            );
        end
    endgenerate

    always_comb
    begin
        del_seen = 1'b0;
        for (int i = 0; i < REPORT_SLOTS; i++)
        begin
            if (cur_codes[i] == KEY_DELETE)
            begin
                del_seen = 1'b1;
            end
        end
        chord = ((report.modifier_bits & MOD_CTRL) != 8'd0)
             && ((report.modifier_bits & MOD_ALT) != 8'd0) && del_seen;
    end

    // advance the previous report on every accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REPORT_SLOTS; i++)
            begin
                prev_reg[i] <= 8'd0;
            end
        end
        else if (in_fire)
        begin
            prev_reg <= cur_codes;
        end
    end

    kre_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_ready (in_ready),
        .lanes    (lanes),
        .chord    (chord),
        .result   (result)
    );

endmodule

// File: rtl/kre_lane.sv
// One slot lane: new-key and gone-key detection plus button and text lookup.
module kre_lane
    import kre_pkg::*;
(
    input  logic [7:0] cur_code,
    input  logic [7:0] prev_code,
    input  logic [7:0] cur_all [REPORT_SLOTS],
    input  logic [7:0] prev_all [REPORT_SLOTS],
    input  logic [7:0] modifier_bits,
    output kre_lane_t  lane
);

    logic cur_seen;
    logic prev_seen;

    always_comb
    begin
        cur_seen  = 1'b0;
        prev_seen = 1'b0;
        for (int j = 0; j < REPORT_SLOTS; j++)
        begin
            if (prev_all[j] == cur_code)
            begin
                cur_seen = 1'b1;
            end
            if (cur_all[j] == prev_code)
            begin
                prev_seen = 1'b1;
            end
        end
    end

    always_comb
    begin
        lane.press     = (cur_code != 8'd0) && !cur_seen;
        lane.gone      = (prev_code != 8'd0) && !prev_seen;
        lane.cur_code  = cur_code;
        lane.prev_code = prev_code;
        lane.cur_btn   = button_of(cur_code);
        lane.prev_btn  = button_of(prev_code);
        lane.text      = text_of(cur_code, (modifier_bits & MOD_SHIFT) != 8'd0);
    end

endmodule

// File: rtl/kre_merge.sv
// Merge stage: buffers lane results and emits events in order, then the status result.
module kre_merge
    import kre_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    output logic               in_ready,
    input  kre_lane_t          lanes [REPORT_SLOTS],
    input  logic               chord,
    kre_result_if.source       result
);

    logic        job_valid_reg;
    kre_lane_t   job_lanes_reg [REPORT_SLOTS];
    logic        job_chord_reg;

    logic                   work_valid_reg;
    logic [EVENT_SLOTS-1:0] pend_reg;
    logic [EVENT_SLOTS-1:0] pend_next;
    kre_lane_t              work_lanes_reg [REPORT_SLOTS];
    logic                   work_chord_reg;

    logic [BUTTONS-1:0] held_reg;
    logic [BUTTONS-1:0] held_next;

    logic        out_valid_reg;
    logic        out_is_event_reg;
    logic        out_pressed_reg;
    logic [7:0]  out_code_reg;
    logic        out_has_reg;
    logic [3:0]  out_idx_reg;
    logic [6:0]  out_text_reg;
    logic [15:0] out_bits_reg;
    logic        out_chord_reg;
    logic        out_last_reg;

    logic             out_free;
    logic             step;
    logic             pend_any;
    logic             finish;
    logic             work_load;
    logic [EVT_W-1:0] sel;
    logic             sel_press;
    logic [7:0]       sel_code;
    kre_button_t      sel_btn;
    logic [6:0]       sel_text;

    assign out_free  = !out_valid_reg || result.ready;
    assign step      = work_valid_reg && out_free;
    assign pend_any  = |pend_reg;
    assign finish    = step && !pend_any;
    assign work_load = job_valid_reg && (!work_valid_reg || finish);
    assign in_ready  = !job_valid_reg || work_load;

    // lowest pending event first: presses in slot order, then releases
    always_comb
    begin
        sel = '0;
        for (int k = EVENT_SLOTS - 1; k >= 0; k--)
        begin
            if (pend_reg[k])
            begin
                sel = EVT_W'(k);
            end
        end
    end

    always_comb
    begin
        sel_press = 1'b0;
        sel_code  = 8'd0;
        sel_btn   = '0;
        sel_text  = 7'd0;
        for (int k = 0; k < REPORT_SLOTS; k++)
        begin
            if (sel == EVT_W'(k))
            begin
                sel_press = 1'b1;
                sel_code  = work_lanes_reg[k].cur_code;
                sel_btn   = work_lanes_reg[k].cur_btn;
                sel_text  = work_lanes_reg[k].text;
            end
            if (sel == EVT_W'(k + REPORT_SLOTS))
            begin
                sel_code = work_lanes_reg[k].prev_code;
                sel_btn  = work_lanes_reg[k].prev_btn;
            end
        end
    end

    always_comb
    begin
        held_next = held_reg;
        if (step && pend_any && sel_btn.has)
        begin
            if (sel_press)
            begin
                held_next = held_reg | (BUTTONS'(1) << sel_btn.idx);
            end
            else
            begin
                held_next = held_reg & ~(BUTTONS'(1) << sel_btn.idx);
            end
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (work_load)
        begin
            for (int k = 0; k < REPORT_SLOTS; k++)
            begin
                pend_next[k]                = job_lanes_reg[k].press;
                pend_next[k + REPORT_SLOTS] = job_lanes_reg[k].gone;
            end
        end
        else if (step && pend_any)
        begin
            pend_next[sel] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg  <= 1'b0;
            work_valid_reg <= 1'b0;
            pend_reg       <= '0;
            held_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                job_valid_reg <= 1'b1;
            end
            else if (work_load)
            begin
                job_valid_reg <= 1'b0;
            end

            if (work_load)
            begin
                work_valid_reg <= 1'b1;
            end
            else if (finish)
            begin
                work_valid_reg <= 1'b0;
            end

            pend_reg <= pend_next;
            held_reg <= held_next;

            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            job_lanes_reg <= lanes;
            job_chord_reg <= chord;
        end
        if (work_load)
        begin
            work_lanes_reg <= job_lanes_reg;
            work_chord_reg <= job_chord_reg;
        end
        if (step)
        begin
            out_is_event_reg <= pend_any;
            out_pressed_reg  <= pend_any && sel_press;
            out_code_reg     <= pend_any ? sel_code : 8'd0;
            out_has_reg      <= pend_any && sel_btn.has;
            out_idx_reg      <= pend_any ? sel_btn.idx : 4'd0;
            out_text_reg     <= (pend_any && sel_press) ? sel_text : 7'd0;
            out_bits_reg     <= held_next;
            out_chord_reg    <= work_chord_reg;
            out_last_reg     <= !pend_any;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.is_event     = out_is_event_reg;
    assign result.pressed      = out_pressed_reg;
    assign result.event_code   = out_code_reg;
    assign result.has_button   = out_has_reg;
    assign result.button_index = out_idx_reg;
    assign result.text_char    = out_text_reg;
    assign result.button_bits  = out_bits_reg;
    assign result.chord_reset  = out_chord_reg;
    assign result.last         = out_last_reg;

endmodule
